// File: design/imf3_pkg.sv
// Shared constants and types for the 3x3 streaming image filter.
package imf3_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 4096;

  localparam int PixW      = 8;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 13;
  localparam int CfgWidthW = 11;
  localparam int CfgHeightW = 13;
  localparam int OutColW   = $clog2(MaxWidth);
  localparam int OutRowW   = $clog2(MaxHeight);
  localparam int SumW      = 13;
  localparam int MinDim    = 3;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;

  typedef logic [PixW-1:0] pix_t;

endpackage

// File: design/imf3_pix_if.sv
// Pixel input channel.
interface imf3_pix_if import imf3_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// File: design/imf3_res_if.sv
// Filtered result channel.
interface imf3_res_if import imf3_pkg::*; ();
  logic               valid;
  logic               ready;
  pix_t               filtered_value;
  logic [OutColW-1:0] center_column;
  logic [OutRowW-1:0] center_row;
  logic               last_of_frame;

  modport source (output valid, output filtered_value, output center_column,
                  output center_row, output last_of_frame, input ready);
  modport sink   (input valid, input filtered_value, input center_column,
                  input center_row, input last_of_frame, output ready);
endinterface

// File: design/imf3_line_mem.sv
// Line buffer RAM: one write port, one read port with registered read data.
module imf3_line_mem #(
  parameter int Depth = 1024,
  parameter int DataW = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [DataW-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [DataW-1:0]         rd_data_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/image_filter_3x3_stream.sv
// Top level of the 3x3 streaming image filter.
// Takes one 8-bit pixel per cycle in raster order and applies the kernel
// 1 2 1 / 2 -8 2 / 1 2 1, emitting one result for each interior pixel with
// its centre coordinates; border pixels give no result. An accepted pixel
// reads the two line buffers (one RAM, upper and middle row packed in a
// word) at its accepting edge; the kernel sum is formed in the next cycle
// and is registered in the output register when stage 1 advances, which
// waits while a result is stalled. Throughput is one pixel per cycle as long
// as results are taken; the single-port-per-direction line RAM sets that pace.
// A width or height register write restarts the frame at row 0, column 0.
module image_filter_3x3_stream import imf3_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  imf3_pix_if.sink            pix_i,
  imf3_res_if.source          res_o
);

  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int DimWW     = $clog2(MaxWidth + 1);
  localparam int DimHW     = $clog2(MaxHeight + 1);
  localparam int WidthRst  = (640 > MaxWidth) ? MaxWidth : 640;
  localparam int HeightRst = (480 > MaxHeight) ? MaxHeight : 480;

  logic [DimWW-1:0] width_q, width_d;
  logic [DimHW-1:0] height_q, height_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             cfg_hit;
  logic [31:0]      cfg_wv, cfg_hv;

  logic             in_fire, in_rdy;
  logic             col_last, row_last;

  logic             s1_vld_q;
  pix_t             s1_pix_q;
  logic [ColW-1:0]  s1_col_q;
  logic [RowW-1:0]  s1_row_q;
  logic             s1_emit_q;
  logic             s1_last_q;
  logic             s1_adv;

  logic [2*PixW-1:0] rd_data;
  pix_t              top, mid, bot;
  pix_t              win_q [6];
  logic signed [SumW-1:0] sum;

  logic               out_vld_q;
  pix_t               out_val_q;
  logic [OutColW-1:0] out_col_q;
  logic [OutRowW-1:0] out_row_q;
  logic               out_last_q;

  // configuration, clamped to the legal range
  always_comb begin
    cfg_wv = 32'(cfg_data_i[CfgWidthW-1:0]);
    cfg_hv = 32'(cfg_data_i[CfgHeightW-1:0]);
    width_d  = width_q;
    height_d = height_q;
    cfg_hit  = 1'b0;
    if (cfg_we_i && cfg_idx_i == RegImageWidth) begin
      cfg_hit = 1'b1;
      if (cfg_wv < 32'(MinDim)) begin
        width_d = DimWW'(MinDim);
      end else if (cfg_wv > 32'(MaxWidth)) begin
        width_d = DimWW'(MaxWidth);
      end else begin
        width_d = DimWW'(cfg_wv);
      end
    end else if (cfg_we_i && cfg_idx_i == RegImageHeight) begin
      cfg_hit = 1'b1;
      if (cfg_hv < 32'(MinDim)) begin
        height_d = DimHW'(MinDim);
      end else if (cfg_hv > 32'(MaxHeight)) begin
        height_d = DimHW'(MaxHeight);
      end else begin
        height_d = DimHW'(cfg_hv);
      end
    end
  end

  // position counters
  assign col_last = (DimWW'(col_q) == width_q - DimWW'(1));
  assign row_last = (DimHW'(row_q) == height_q - DimHW'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimWW'(WidthRst);
      height_q <= DimHW'(HeightRst);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // handshake
  assign s1_adv    = s1_vld_q && (!out_vld_q || res_o.ready);
  assign in_rdy    = !s1_vld_q || s1_adv;
  assign in_fire   = pix_i.valid && in_rdy;
  assign pix_i.ready = in_rdy;

  // stage 1 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_fire) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= pix_i.pixel_in;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_emit_q <= (row_q >= RowW'(2)) && (col_q >= ColW'(2));
      s1_last_q <= col_last && row_last;
    end
  end

  // line buffers: {upper, middle} per column
  imf3_line_mem #(
    .Depth (MaxWidth),
    .DataW (2 * PixW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({mid, bot}),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data)
  );

  assign top = rd_data[2*PixW-1:PixW];
  assign mid = rd_data[PixW-1:0];
  assign bot = s1_pix_q;

  // kernel sum; window[0..2] is the older column (top, mid, bottom)
  always_comb begin
    sum = $signed(SumW'(win_q[0])) + ($signed(SumW'(win_q[3])) <<< 1)
        + $signed(SumW'(top))
        + ($signed(SumW'(win_q[1])) <<< 1) - ($signed(SumW'(win_q[4])) <<< 3)
        + ($signed(SumW'(mid)) <<< 1)
        + $signed(SumW'(win_q[2])) + ($signed(SumW'(win_q[5])) <<< 1)
        + $signed(SumW'(bot));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= bot;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= s1_emit_q;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      out_val_q  <= sum[PixW+3:4];
      out_col_q  <= OutColW'(s1_col_q - ColW'(1));
      out_row_q  <= OutRowW'(s1_row_q - RowW'(1));
      out_last_q <= s1_last_q;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.filtered_value = out_val_q;
  assign res_o.center_column  = out_col_q;
  assign res_o.center_row     = out_row_q;
  assign res_o.last_of_frame  = out_last_q;

endmodule

// File: design/imf3_chk.sv
// Port-level checker for the 3x3 streaming image filter, with its bind.
module imf3_chk import imf3_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input pix_t               out_value_i,
  input logic [OutColW-1:0] out_col_i,
  input logic [OutRowW-1:0] out_row_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i)
      && $stable(out_col_i) && $stable(out_row_i))
    else $error("result changed while stalled");

  // a new result is preceded by a pixel transaction
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a source pixel");

  // results only for centres off the first row and the first column
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_col_i != '0) && (out_row_i != '0))
    else $error("border pixel emitted");

endmodule

bind image_filter_3x3_stream imf3_chk u_imf3_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_value_i (res_o.filtered_value),
  .out_col_i   (res_o.center_column),
  .out_row_i   (res_o.center_row)
);
